@@ sv/tdz_pkg.sv @@
// Shared types and constants for the tick delta zigzag encoder.
// No dependencies; imported by tdz_byte_out, tick_delta_zigzag_encoder and its testbench.
package tdz_pkg;

  localparam int unsigned FULL_BYTES = 8;
  localparam int unsigned IDX_W      = $clog2(FULL_BYTES);
  localparam int unsigned SIGN_BIT   = 31;

  localparam logic [7:0]  BYTE_MASK     = 8'hFF;
  localparam logic [15:0] CAP_RESET     = 16'hFFFF;
  localparam logic [15:0] CAP_MIN_START = 16'(FULL_BYTES);
  localparam logic [15:0] DELTA_BYTES   = 16'd2;

  localparam logic [IDX_W-1:0] LAST_IDX_FAIL  = IDX_W'(0);
  localparam logic [IDX_W-1:0] LAST_IDX_DELTA = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX_FULL  = IDX_W'(FULL_BYTES - 1);

  // One tick's worth of output bytes, emitted from index 0 up to last_idx
  typedef struct packed {
    logic [FULL_BYTES-1:0][7:0] data;
    logic [IDX_W-1:0]           last_idx;
    logic                       fail;
  } tdz_pkt_t;

endpackage

@@ sv/tdz_byte_out.sv @@
// Packet register and byte serialiser for the tick delta zigzag encoder.
// Depends on tdz_pkg (tdz_pkt_t, IDX_W).
module tdz_byte_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tdz_pkg::tdz_pkt_t load_pkt,
  output logic            load_ready,
  output logic            byte_valid,
  input  logic            byte_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            block_failed
);
  import tdz_pkg::*;

  tdz_pkt_t         pkt;
  logic             pkt_valid;
  logic [IDX_W-1:0] idx;
  logic             xfer;
  logic             xfer_last;

  assign byte_valid   = pkt_valid;
  assign out_byte     = pkt.data[idx];
  assign last_of_run  = (idx == pkt.last_idx);
  assign block_failed = pkt.fail;

  assign xfer       = pkt_valid && !byte_stall;
  assign xfer_last  = xfer && last_of_run;
  assign load_ready = !pkt_valid || xfer_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      pkt_valid <= 1'b1;
      idx       <= '0;
    end else if (xfer_last) begin
      pkt_valid <= 1'b0;
    end else if (xfer) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt <= load_pkt;
    end
  end

  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && pkt.fail) |-> (last_of_run && out_byte == 8'd0))
    else $error("failure result is not a single zero byte");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (xfer && !last_of_run) |=> (pkt_valid && idx == $past(idx) + IDX_W'(1)))
    else $error("byte run broken before its last transfer");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> (idx <= pkt.last_idx))
    else $error("byte index past end of packet");

endmodule

@@ sv/tick_delta_zigzag_encoder.sv @@
// Top level of the tick delta zigzag encoder: input register, block state,
// encode logic and configuration. Depends on tdz_pkg and tdz_byte_out.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  tick in   | tick_valid / tick_stall   | tick_time, tick_price, start_block
//  byte out  | byte_valid / byte_stall   | out_byte, last_of_run, block_failed
//  capacity  | capacity_we               | capacity_data
//
// A tick is registered, encoded in one pass into a packet of 1, 2 or 8 bytes,
// and the packet register emits one byte per cycle unless byte_stall holds it
// back; a tick holds the output until its last byte transfers. The input
// register takes the next tick while the packet is still draining. A tick goes
// through the input register and then the packet register to its first byte.
// Synchronous reset clears valids and block state, sets capacity to 65535.
module tick_delta_zigzag_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic [31:0] tick_time,
  input  logic signed [31:0] tick_price,
  input  logic        start_block,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        block_failed,
  input  logic        capacity_we,
  input  logic [15:0] capacity_data
);
  import tdz_pkg::*;

  logic [15:0] capacity;

  logic        iv;
  logic [31:0] it;
  logic [31:0] ip;
  logic        is_start;

  logic [31:0] previous_time, previous_time_next;
  logic [31:0] previous_price, previous_price_next;
  logic [15:0] bytes_written, bytes_written_next;
  logic        failed_flag, failed_flag_next;

  logic        load_ready;
  logic        adv;
  tdz_pkt_t    pkt_next;

  logic [31:0] dt;
  logic [31:0] dp;
  logic [31:0] zz;
  logic [16:0] bw_plus;

  assign adv        = iv && load_ready;
  assign tick_stall = iv && !load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_data;
    end
  end

  // Input register: refill when empty or when its tick moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!tick_stall) begin
      iv <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      it       <= tick_time;
      ip       <= tick_price;
      is_start <= start_block;
    end
  end

  assign dt      = it - previous_time;
  assign dp      = ip - previous_price;
  assign zz      = {dp[SIGN_BIT-1:0], 1'b0} ^ {32{dp[SIGN_BIT]}};
  assign bw_plus = {1'b0, bytes_written} + {1'b0, DELTA_BYTES};

  always_comb begin
    previous_time_next  = previous_time;
    previous_price_next = previous_price;
    bytes_written_next  = bytes_written;
    failed_flag_next    = failed_flag;
    pkt_next.data       = '0;
    pkt_next.last_idx   = LAST_IDX_FAIL;
    pkt_next.fail       = 1'b1;
    priority if (is_start) begin
      failed_flag_next   = 1'b0;
      bytes_written_next = '0;
      if (capacity < CAP_MIN_START) begin
        failed_flag_next = 1'b1;
      end else begin
        pkt_next.data       = {ip, it};
        pkt_next.last_idx   = LAST_IDX_FULL;
        pkt_next.fail       = 1'b0;
        previous_time_next  = it;
        previous_price_next = ip;
        bytes_written_next  = CAP_MIN_START;
      end
    end else if (failed_flag) begin
      // stay failed, state held
    end else if (bw_plus > {1'b0, capacity}) begin
      failed_flag_next = 1'b1;
    end else if (dt > {24'd0, BYTE_MASK} || zz > {24'd0, BYTE_MASK}) begin
      failed_flag_next = 1'b1;
    end else begin
      pkt_next.data[0]    = dt[7:0];
      pkt_next.data[1]    = zz[7:0];
      pkt_next.last_idx   = LAST_IDX_DELTA;
      pkt_next.fail       = 1'b0;
      previous_time_next  = it;
      previous_price_next = ip;
      bytes_written_next  = bw_plus[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time  <= '0;
      previous_price <= '0;
      bytes_written  <= '0;
      failed_flag    <= 1'b0;
    end else if (adv) begin
      previous_time  <= previous_time_next;
      previous_price <= previous_price_next;
      bytes_written  <= bytes_written_next;
      failed_flag    <= failed_flag_next;
    end
  end

  tdz_byte_out u_byte_out (
    .clk          (clk),
    .rst          (rst),
    .load         (adv),
    .load_pkt     (pkt_next),
    .load_ready   (load_ready),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .block_failed (block_failed)
  );

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && is_start && capacity >= CAP_MIN_START) |=>
      (!failed_flag && bytes_written == CAP_MIN_START))
    else $error("start tick did not reset block state");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    (adv && !is_start && failed_flag) |=> failed_flag)
    else $error("failed block recovered without a start tick");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (iv && byte_valid))
    else $error("input held with no tick waiting on the output");

endmodule

@@ verif/tick_delta_zigzag_encoder_tb.sv @@
// Self-checking testbench for tick_delta_zigzag_encoder: directed and random tick
// streams, random gaps and stalls, and a byte-by-byte check against a local encoder.
// Depends on tdz_pkg and the encoder RTL.
module tick_delta_zigzag_encoder_tb;
  import tdz_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       is_fail;
  } byte_rec_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned PHASE_TICKS  = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  logic [31:0] tick_time = '0;
  logic [31:0] tick_price = '0;
  logic        start_block = 1'b0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        block_failed;
  logic        capacity_we = 1'b0;
  logic [15:0] capacity_data = '0;

  tick_delta_zigzag_encoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .tick_valid    (tick_valid),
    .tick_stall    (tick_stall),
    .tick_time     (tick_time),
    .tick_price    (tick_price),
    .start_block   (start_block),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .block_failed  (block_failed),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data)
  );

  always #1 clk = ~clk;

  // Encoder state as seen by the testbench
  logic [15:0] cap_q       = CAP_RESET;
  logic [31:0] ref_time    = '0;
  logic [31:0] ref_price   = '0;
  logic [15:0] block_bytes = '0;
  logic        block_bad   = 1'b0;
  byte_rec_t   pending_bytes[$];

  int errors = 0;
  int unsigned cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int hold_req_id = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] zigzag(input logic [31:0] d);
    return {d[30:0], 1'b0} ^ {32{d[31]}};
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic is_last,
                                    input logic is_fail);
    pending_bytes.push_back(byte_rec_t'{data: b, is_last: is_last, is_fail: is_fail});
  endfunction

  function automatic void fail_block();
    block_bad = 1'b1;
    push_byte(8'h00, 1'b1, 1'b1);
  endfunction

  function automatic void encode_tick(input logic [31:0] t, input logic [31:0] p,
                                      input logic s);
    logic [31:0] dt;
    logic [31:0] dp;
    if (s) begin
      block_bad = 1'b0;
      block_bytes = '0;
      if (cap_q < 16'(FULL_BYTES)) begin
        fail_block();
        return;
      end
      for (int i = 0; i < 4; i++) push_byte(t[8*i +: 8], 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) push_byte(p[8*i +: 8], i == 3, 1'b0);
      ref_time = t;
      ref_price = p;
      block_bytes = 16'(FULL_BYTES);
      return;
    end
    // capacity is checked ahead of the deltas
    if (block_bad || ({1'b0, block_bytes} + 17'(DELTA_BYTES) > {1'b0, cap_q})) begin
      fail_block();
      return;
    end
    dt = t - ref_time;
    dp = zigzag(p - ref_price);
    if (dt > 32'(BYTE_MASK) || dp > 32'(BYTE_MASK)) begin
      fail_block();
      return;
    end
    push_byte(dt[7:0], 1'b0, 1'b0);
    push_byte(dp[7:0], 1'b1, 1'b0);
    ref_time = t;
    ref_price = p;
    block_bytes = block_bytes + DELTA_BYTES;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Entered and left at a rising edge; the transfer edge is the exit edge
  task automatic send_tick(input logic [31:0] t, input logic [31:0] p, input logic s);
    int gap;
    bit fire;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_time <= t;
    tick_price <= p;
    start_block <= s;
    do begin
      @(negedge clk);
      fire = !tick_stall;
      @(posedge clk);
    end while (!fire);
    encode_tick(t, p, s);
  endtask

  task automatic wait_idle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    capacity_we <= 1'b1;
    capacity_data <= v;
    @(posedge clk);
    capacity_we <= 1'b0;
    cap_q = v;
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : stall_gen
    int r;
    int hold_ack;
    int hold_left;
    int burst_left;
    if (hold_req_id != hold_ack) begin
      hold_ack = hold_req_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      byte_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      byte_stall <= 1'b1;
    end else if (!stalls_on) begin
      byte_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        byte_stall <= 1'b0;
      end else if (r < 96) begin
        byte_stall <= 1'b1;
        burst_left = $urandom_range(0, 2);
      end else begin
        byte_stall <= 1'b1;
        burst_left = $urandom_range(8, 40);
      end
    end
  end

  // Sample ahead of the edge, check at the edge
  bit        out_fire = 1'b0;
  byte_rec_t out_seen;
  byte_rec_t want;

  always @(negedge clk) begin
    out_fire = !rst && byte_valid && !byte_stall;
    out_seen = byte_rec_t'{data: out_byte, is_last: last_of_run, is_fail: block_failed};
  end

  always @(posedge clk) begin
    if (out_fire) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte transfer", 32'(out_seen), 0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_seen.data !== want.data)
          report_mismatch("out_byte", 32'(out_seen.data), 32'(want.data));
        if (out_seen.is_last !== want.is_last)
          report_mismatch("last_of_run", 32'(out_seen.is_last), 32'(want.is_last));
        if (out_seen.is_fail !== want.is_fail)
          report_mismatch("block_failed", 32'(out_seen.is_fail), 32'(want.is_fail));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tick_delta_zigzag_encoder_tb NOT OK");
      $finish;
    end
  end

  // Ticks before any start mark are deltas against zero
  task automatic test_reset_state();
    send_tick(32'd5, 32'd3, 1'b0);
    send_tick(32'h105, 32'd3, 1'b0);
    send_tick(32'h106, 32'd4, 1'b0);
    wait_idle();
  endtask

  task automatic test_start_and_deltas();
    send_tick(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_tick(32'h0000_00FE, 32'h7FFF_FF80, 1'b0);
    send_tick(32'h0000_00FE, 32'h7FFF_FFFF, 1'b0);
    send_tick(32'h0000_00FE, 32'h8000_0005, 1'b0);
    send_tick(32'h0000_00FF, 32'h8000_0085, 1'b0);
    send_tick(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_tick(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_tick(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_tick(32'h0000_0100, 32'h0000_0000, 1'b0);
    send_tick(32'h1234_5678, 32'hA5A5_A5A5, 1'b1);
    send_tick(32'h1234_5679, 32'hA5A5_A5A4, 1'b0);
    wait_idle();
  endtask

  task automatic test_capacity();
    set_capacity(16'd7);
    send_tick(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1);
    wait_idle();
    set_capacity(16'd8);
    send_tick(32'd100, 32'd200, 1'b1);
    send_tick(32'd101, 32'd200, 1'b0);
    wait_idle();
    set_capacity(16'd12);
    send_tick(32'd100, 32'd200, 1'b1);
    send_tick(32'd110, 32'd190, 1'b0);
    send_tick(32'd120, 32'd210, 1'b0);
    send_tick(32'd130, 32'd210, 1'b0);
    wait_idle();
    set_capacity(16'd0);
    send_tick(32'd1, 32'd1, 1'b1);
    wait_idle();
    set_capacity(CAP_RESET);
  endtask

  // Hold the output off while ticks keep coming, so the input side stalls
  task automatic test_backpressure();
    logic [31:0] t;
    logic [31:0] p;
    gaps_on = 1'b0;
    hold_req_id++;
    t = $urandom;
    p = $urandom;
    send_tick(t, p, 1'b1);
    repeat (15) begin
      t = t + $urandom_range(0, 255);
      p = p + 32'(int'($urandom_range(0, 255)) - 128);
      send_tick(t, p, 1'b0);
    end
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic run_random_phase(input int unsigned n_ticks);
    logic [31:0] t;
    logic [31:0] p;
    int run_len;
    int r;
    int unsigned sent;
    sent = 0;
    while (sent < n_ticks) begin
      t = $urandom;
      p = $urandom;
      send_tick(t, p, 1'b1);
      sent++;
      run_len = $urandom_range(1, 24);
      for (int i = 0; i < run_len && sent < n_ticks; i++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // break the sequence with a step that is too large
          t = $urandom;
          p = $urandom;
        end else if (r < 10) begin
          t = t + $urandom_range(0, 255);
          p = p + 32'($urandom_range(128, 4096));
        end else begin
          t = t + $urandom_range(0, 255);
          p = p + 32'(int'($urandom_range(0, 255)) - 128);
        end
        send_tick(t, p, 1'b0);
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic test_random();
    set_capacity(CAP_RESET);
    run_random_phase(PHASE_TICKS);
    set_capacity(16'($urandom_range(8, 40)));
    run_random_phase(PHASE_TICKS);
    set_capacity(16'($urandom_range(0, 9)));
    run_random_phase(PHASE_TICKS);
    // steady stretch with no idling on either side
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_capacity(16'hFFFF);
    run_random_phase(PHASE_TICKS);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_start_and_deltas();
    test_capacity();
    test_backpressure();
    test_random();
    wait_idle();
    if (pending_bytes.size() != 0)
      report_mismatch("bytes never transferred", unsigned'(pending_bytes.size()), 0);
    if (errors == 0) begin
      $display("tick_delta_zigzag_encoder_tb OK");
    end else begin
      $display("tick_delta_zigzag_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tdz_pkg.sv
sv/tdz_byte_out.sv
sv/tick_delta_zigzag_encoder.sv
verif/tick_delta_zigzag_encoder_tb.sv
